// ===== rtl/upd_pkg.sv =====
// Shared types, character codes and helper functions for the URL percent decoder.
// No dependencies; used by every module under rtl/.

package upd_pkg;

	localparam logic [7:0] ChPercent = 8'h25;
	localparam logic [7:0] ChPlus    = 8'h2B;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChZero    = 8'h30;
	localparam logic [7:0] ChNine    = 8'h39;
	localparam logic [7:0] ChUpperA  = 8'h41;
	localparam logic [7:0] ChUpperF  = 8'h46;
	localparam logic [7:0] ChLowerA  = 8'h61;
	localparam logic [7:0] ChLowerF  = 8'h66;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef enum logic [1:0] {
		HELD_NONE  = 2'd0,
		HELD_PCT   = 2'd1,
		HELD_DIGIT = 2'd2
	} held_t;

	// one queue entry: all result bytes of one input byte, slot 0 goes first
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;   // 1..3
		logic            last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= ChZero && c <= ChNine) ||
		         (c >= ChUpperA && c <= ChUpperF) ||
		         (c >= ChLowerA && c <= ChLowerF);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		v = c;
		if (v >= ChLowerA) v = v - (ChLowerA - ChUpperA);
		if (v >= ChUpperA) v = v - (ChUpperA - 8'd10);
		else v = v - ChZero;
		hex_nib = v[3:0];
	endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: accepts encoded bytes, tracks the pending percent sequence and
// builds one queue entry with all bytes each input produces. Uses upd_pkg.

module upd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              push,
	output upd_pkg::entry_t   entry
);

	upd_pkg::held_t held_q;
	logic [7:0]     digit_q;

	upd_pkg::held_t  held_d;
	logic [7:0]      digit_d;
	logic [2:0][7:0] bytes;
	logic [1:0]      n;
	logic            hex;
	logic            plain_hold;
	logic [7:0]      plain_byte;

	always_comb begin
		hex        = upd_pkg::is_hex(in_byte);
		plain_hold = (in_byte == upd_pkg::ChPercent);
		plain_byte = (in_byte == upd_pkg::ChPlus) ? upd_pkg::ChSpace : in_byte;
		bytes      = '0;
		n          = 2'd0;
		held_d     = upd_pkg::HELD_NONE;
		digit_d    = digit_q;

		unique case (held_q)
			upd_pkg::HELD_PCT: begin
				if (hex) begin
					held_d  = upd_pkg::HELD_DIGIT;
					digit_d = in_byte;
				end else begin
					bytes[0] = upd_pkg::ChPercent;
					bytes[1] = plain_byte;
					n        = plain_hold ? 2'd1 : 2'd2;
					held_d   = plain_hold ? upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
				end
			end
			upd_pkg::HELD_DIGIT: begin
				if (hex) begin
					bytes[0] = {upd_pkg::hex_nib(digit_q), upd_pkg::hex_nib(in_byte)};
					n        = 2'd1;
				end else begin
					bytes[0] = upd_pkg::ChPercent;
					bytes[1] = digit_q;
					bytes[2] = plain_byte;
					n        = plain_hold ? 2'd2 : 2'd3;
					held_d   = plain_hold ? upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
				end
			end
			default: begin
				bytes[0] = plain_byte;
				n        = plain_hold ? 2'd0 : 2'd1;
				held_d   = plain_hold ? upd_pkg::HELD_PCT : upd_pkg::HELD_NONE;
			end
		endcase

		// end of string: flush whatever is still held; never exceeds three slots
		if (in_last) begin
			if (held_d != upd_pkg::HELD_NONE) begin
				unique case (n)
					2'd0:    bytes[0] = upd_pkg::ChPercent;
					2'd1:    bytes[1] = upd_pkg::ChPercent;
					default: bytes[2] = upd_pkg::ChPercent;
				endcase
				n = n + 2'd1;
			end
			if (held_d == upd_pkg::HELD_DIGIT) begin
				unique case (n)
					2'd1:    bytes[1] = digit_d;
					default: bytes[2] = digit_d;
				endcase
				n = n + 2'd1;
			end
			held_d  = upd_pkg::HELD_NONE;
			digit_d = '0;
		end
	end

	assign push        = acc && (n != 2'd0);
	assign entry.bytes = bytes;
	assign entry.cnt   = n;
	assign entry.last  = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= upd_pkg::HELD_NONE;
			digit_q <= '0;
		end else if (acc) begin
			held_q  <= held_d;
			digit_q <= digit_d;
		end
	end

endmodule

// ===== rtl/upd_queue.sv =====
// Small FIFO of result entries between front and back end.
// Uses upd_pkg for the entry type and depth.

module upd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  upd_pkg::entry_t    wr_entry,
	input  logic               pop,
	output upd_pkg::entry_t    rd_entry,
	output upd_pkg::q_status_t status
);

	upd_pkg::entry_t          mem_q [upd_pkg::QDepth];
	logic [upd_pkg::QAw-1:0]  wr_ptr_q;
	logic [upd_pkg::QAw-1:0]  rd_ptr_q;
	logic [upd_pkg::QAw:0]    count_q;

	assign rd_entry     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == (upd_pkg::QAw+1)'(upd_pkg::QDepth));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + upd_pkg::QAw'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + upd_pkg::QAw'(1);
			if (push && !pop)      count_q <= count_q + (upd_pkg::QAw+1)'(1);
			else if (pop && !push) count_q <= count_q - (upd_pkg::QAw+1)'(1);
		end
	end

endmodule

// ===== rtl/upd_back.sv =====
// Back end: steps through the bytes of the head entry, one per cycle while the
// output is accepted, into the output register. Uses upd_pkg.

module upd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  upd_pkg::entry_t    head,
	input  upd_pkg::q_status_t q_status,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic load;
	logic final_slot;

	assign load       = !q_status.empty && (!valid_q || m_tready);
	assign final_slot = (idx_q == head.cnt - 2'd1);
	assign pop        = load && final_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_slot ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= head.last && final_slot;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// Top level of the streaming URL percent decoder: front end, entry queue, back end.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//  channel | dir | tdata (low bit up) | tlast
//  s_*     | in  | in_byte [7:0]      | in_last
//  m_*     | out | out_byte [7:0]     | out_last
//
// One input transfer per cycle while the entry queue (4 deep) has room.
// Output is one byte per cycle while m_tready is high; an input giving two or three
// bytes holds the back end until all are out, so input stalls only once the queue fills.
// m_tvalid for the first result rises after it passes the entry queue, then the output register.
// Asynchronous reset clears the held sequence, queue pointers and output valid.

module url_percent_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	logic               acc;
	logic               push;
	logic               pop;
	upd_pkg::entry_t    wr_entry;
	upd_pkg::entry_t    head;
	upd_pkg::q_status_t q_status;

	assign s_tready = !q_status.full;
	assign acc      = s_tvalid && s_tready;

	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.push    (push),
		.entry   (wr_entry)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.status   (q_status)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("entry queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("entry queue underflow");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tlast |-> push)
		else $error("final input transfer produced no result");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		!q_status.empty |-> head.cnt != 2'd0)
		else $error("queued entry has no bytes");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_decoder_unit: directed and random strings with stalls on both sides.
// Depends on upd_pkg and the decoder RTL; the expected stream comes from a built-in predictor.

module testbench;

	localparam int CycleLimit = 200000;
	localparam int RandomItems = 200;

	typedef logic [7:0] byte_q_t[$];

	// Predicts decoded bytes from the encoded input and checks each output transfer.
	class url_decode_scoreboard;
		typedef struct {
			logic [7:0] chr;
			logic       last;
		} dec_char_t;

		dec_char_t       pending_chars[$];
		upd_pkg::held_t  held;
		logic [7:0]      held_digit;
		int              mismatches;
		int              checked;

		function new();
			held = upd_pkg::HELD_NONE;
			held_digit = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function bit is_hex_char(logic [7:0] c);
			return (c >= upd_pkg::ChZero && c <= upd_pkg::ChNine) ||
			       (c >= upd_pkg::ChUpperA && c <= upd_pkg::ChUpperF) ||
			       (c >= upd_pkg::ChLowerA && c <= upd_pkg::ChLowerF);
		endfunction

		function logic [3:0] nibble(logic [7:0] c);
			logic [7:0] v;
			if (c <= upd_pkg::ChNine) v = c - upd_pkg::ChZero;
			else if (c <= upd_pkg::ChUpperF) v = c - upd_pkg::ChUpperA + 8'd10;
			else v = c - upd_pkg::ChLowerA + 8'd10;
			return v[3:0];
		endfunction

		function void push_char(logic [7:0] c);
			dec_char_t d;
			d.chr = c;
			d.last = 1'b0;
			pending_chars.push_back(d);
		endfunction

		// byte seen with nothing held
		function void pass_plain(logic [7:0] c);
			if (c == upd_pkg::ChPercent) held = upd_pkg::HELD_PCT;
			else if (c == upd_pkg::ChPlus) push_char(upd_pkg::ChSpace);
			else push_char(c);
		endfunction

		function void note_encoded(logic [7:0] c, logic last);
			int base;
			dec_char_t d;
			base = pending_chars.size();
			case (held)
				upd_pkg::HELD_PCT: begin
					if (is_hex_char(c)) begin
						held_digit = c;
						held = upd_pkg::HELD_DIGIT;
					end else begin
						push_char(upd_pkg::ChPercent);
						held = upd_pkg::HELD_NONE;
						pass_plain(c);
					end
				end
				upd_pkg::HELD_DIGIT: begin
					if (is_hex_char(c)) begin
						push_char({nibble(held_digit), nibble(c)});
						held = upd_pkg::HELD_NONE;
					end else begin
						push_char(upd_pkg::ChPercent);
						push_char(held_digit);
						held = upd_pkg::HELD_NONE;
						pass_plain(c);
					end
				end
				default: begin
					held = upd_pkg::HELD_NONE;
					pass_plain(c);
				end
			endcase
			if (last) begin
				// flush a cut-off escape literally
				if (held != upd_pkg::HELD_NONE) push_char(upd_pkg::ChPercent);
				if (held == upd_pkg::HELD_DIGIT) push_char(held_digit);
				held = upd_pkg::HELD_NONE;
				held_digit = '0;
				if (pending_chars.size() > base) begin
					d = pending_chars.pop_back();
					d.last = 1'b1;
					pending_chars.push_back(d);
				end
			end
		endfunction

		function void check_decoded(logic [7:0] c, logic last);
			dec_char_t want;
			if (pending_chars.size() == 0) begin
				$error("unexpected transfer: out_byte %h out_last %b", c, last);
				mismatches++;
				return;
			end
			want = pending_chars.pop_front();
			checked++;
			if (want.chr !== c) begin
				$error("out_byte: expected %h, got %h", want.chr, c);
				mismatches++;
			end
			if (want.last !== last) begin
				$error("out_last: expected %b, got %b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	url_decode_scoreboard board;
	int items_sent = 0;
	int cycle_count = 0;
	bit quiet_source = 1'b0;
	bit quiet_sink = 1'b0;

	url_percent_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = quiet_source ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_encoded(c, last);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_encoded(input byte_q_t enc);
		for (int i = 0; i < enc.size(); i++) send_char(enc[i], i == enc.size() - 1);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending_chars.size() != 0);
	endtask

	function automatic logic [7:0] hex_char(int n);
		if (n < 10) return upd_pkg::ChZero + 8'(n);
		return ($urandom_range(0, 1) ? upd_pkg::ChUpperA : upd_pkg::ChLowerA) + 8'(n - 10);
	endfunction

	// well-formed escapes with random content, plain bytes, plus signs, and broken and cut-off escapes
	function automatic byte_q_t random_string();
		byte_q_t q;
		int kind;
		logic [7:0] c;
		repeat ($urandom_range(1, 6)) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				q.push_back(8'($urandom_range(32, 126)));
			end else if (kind < 60) begin
				q.push_back(upd_pkg::ChPercent);
				q.push_back(hex_char($urandom_range(0, 15)));
				q.push_back(hex_char($urandom_range(0, 15)));
			end else if (kind < 70) begin
				q.push_back(upd_pkg::ChPlus);
			end else if (kind < 85) begin
				q.push_back(upd_pkg::ChPercent);
				if ($urandom_range(0, 1)) q.push_back(hex_char($urandom_range(0, 15)));
				do c = 8'($urandom_range(1, 255)); while (board.is_hex_char(c));
				q.push_back(c);
			end else begin
				q.push_back(8'($urandom_range(1, 255)));
			end
		end
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			q.push_back(upd_pkg::ChPercent);
		end else if (kind == 1) begin
			q.push_back(upd_pkg::ChPercent);
			q.push_back(hex_char($urandom_range(0, 15)));
		end
		return q;
	endfunction

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet_sink ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_decoded(m_tdata, m_tlast);
		end
	end

	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		byte_q_t enc;
		int drain_point;
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digit and letter bounds, both cases, zero result, plus,
		// broken escapes and escapes cut off by the end of the string
		send_text("%41");
		send_text("%fF%00");
		send_char(8'h01, 1'b0);
		send_char(upd_pkg::ChPlus, 1'b0);
		send_char(8'hFF, 1'b1);
		send_text("%G");
		send_text("%9+");
		send_text("%a%");
		send_text("%");
		send_text("%7");

		hold_until_drained();

		drain_point = items_sent + RandomItems / 2;
		while (items_sent < RandomItems) begin
			quiet_source = ($urandom_range(0, 5) == 0);
			quiet_sink = ($urandom_range(0, 5) == 0);
			enc = random_string();
			send_encoded(enc);
			if (items_sent >= drain_point && drain_point > 0) begin
				hold_until_drained();
				drain_point = 0;
			end
		end

		hold_until_drained();
		repeat (20) @(posedge clk);

		if (board.pending_chars.size() != 0)
			$error("%0d expected bytes never arrived", board.pending_chars.size());
		$display("%0d encoded bytes sent, %0d decoded bytes checked", items_sent, board.checked);
		$display("escapes, plus signs, broken and cut-off sequences under random stalls");
		if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_unit.sv
sim/testbench.sv
